FILE: hdl/ptbp_pkg.sv
// ----------------------------------------------------------------------------
// ptbp_pkg
// Types and constants shared by the percent text parser: parse phases,
// parser state record and the character codes it recognizes.
// ----------------------------------------------------------------------------
package ptbp_pkg;

	localparam int unsigned WholeW = 25;
	localparam int unsigned HundW  = 7;
	localparam int unsigned FcntW  = 2;

	localparam logic [WholeW-1:0] MaxWhole = 25'd21474836;

	localparam logic [7:0] CharZero  = 8'h30;
	localparam logic [7:0] CharPlus  = 8'h2B;
	localparam logic [7:0] CharMinus = 8'h2D;
	localparam logic [7:0] CharPoint = 8'h2E;
	localparam logic [7:0] CharPct   = 8'h25;
	localparam logic [7:0] CharSemi  = 8'h3B;
	localparam logic [7:0] CharSpace = 8'h20;
	localparam logic [7:0] CharTab   = 8'h09;
	localparam logic [7:0] CharCr    = 8'h0D;

	typedef enum logic [3:0] {
		PH_LEAD,
		PH_SIGN,
		PH_INT,
		PH_POINT,
		PH_FRAC,
		PH_TRAIL,
		PH_PCT,
		PH_DONE,
		PH_ERROR
	} phase_t;

	typedef struct packed {
		phase_t             phase;
		logic               neg;
		logic [WholeW-1:0]  whole;
		logic [HundW-1:0]   hund;
		logic [FcntW-1:0]   fcnt;
	} parse_state_t;

	localparam parse_state_t StateReset = '{
		phase: PH_LEAD,
		neg:   1'b0,
		whole: '0,
		hund:  '0,
		fcnt:  '0
	};

endpackage

FILE: hdl/ptbp_parse_step.sv
// ----------------------------------------------------------------------------
// ptbp_parse_step
// Next parser state for one text character: phase transitions, sign,
// whole part accumulation with overflow check and hundredths accumulation.
// ----------------------------------------------------------------------------
module ptbp_parse_step (
	input  ptbp_pkg::parse_state_t cur,
	input  logic [7:0]             character,
	output ptbp_pkg::parse_state_t nxt
);
	import ptbp_pkg::*;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CharZero) && (c <= (CharZero + 8'd9));
	endfunction

	function automatic phase_t number_end(input logic [7:0] c);
		phase_t p;
		priority if (is_ws(c)) begin
			p = PH_TRAIL;
		end else if (c == CharPct) begin
			p = PH_PCT;
		end else if (c == CharSemi) begin
			p = PH_DONE;
		end else begin
			p = PH_ERROR;
		end
		return p;
	endfunction

	logic [3:0]          digit;
	logic                dig;
	logic [WholeW+3:0]   whole_sum;
	logic                whole_ovf;
	logic [HundW-1:0]    hund_sum;
	logic                do_whole;
	logic                do_frac;

	// low nibble of an ascii digit is its value
	assign digit     = character[3:0];
	assign dig       = is_digit(character);
	assign whole_sum = {1'b0, cur.whole, 3'b000} + {3'b000, cur.whole, 1'b0}
		+ {{(WholeW){1'b0}}, digit};
	assign whole_ovf = whole_sum > {4'b0000, MaxWhole};
	assign hund_sum  = {cur.hund[HundW-4:0], 3'b000} + {1'b0, cur.hund[HundW-3:0], 1'b0}
		+ {3'b000, digit};

	always_comb begin
		nxt      = cur;
		do_whole = 1'b0;
		do_frac  = 1'b0;
		unique case (cur.phase)
			PH_LEAD: begin
				priority if (is_ws(character)) begin
					nxt.phase = PH_LEAD;
				end else if (character == CharPlus || character == CharMinus) begin
					nxt.neg   = (character == CharMinus);
					nxt.phase = PH_SIGN;
				end else if (dig) begin
					nxt.phase = PH_INT;
					do_whole  = 1'b1;
				end else begin
					nxt.phase = PH_ERROR;
				end
			end
			PH_SIGN: begin
				if (dig) begin
					nxt.phase = PH_INT;
					do_whole  = 1'b1;
				end else begin
					nxt.phase = PH_ERROR;
				end
			end
			PH_INT: begin
				priority if (dig) begin
					do_whole = 1'b1;
				end else if (character == CharPoint) begin
					nxt.phase = PH_POINT;
				end else begin
					nxt.phase = number_end(character);
				end
			end
			PH_POINT: begin
				if (dig) begin
					nxt.phase = PH_FRAC;
					do_frac   = 1'b1;
				end else begin
					nxt.phase = PH_ERROR;
				end
			end
			PH_FRAC: begin
				if (dig) begin
					do_frac = 1'b1;
				end else begin
					nxt.phase = number_end(character);
				end
			end
			PH_TRAIL: begin
				priority if (is_ws(character)) begin
					nxt.phase = PH_TRAIL;
				end else if (character == CharPct) begin
					nxt.phase = PH_PCT;
				end else if (character == CharSemi) begin
					nxt.phase = PH_DONE;
				end else begin
					nxt.phase = PH_ERROR;
				end
			end
			PH_PCT: begin
				priority if (is_ws(character)) begin
					nxt.phase = PH_PCT;
				end else if (character == CharSemi) begin
					nxt.phase = PH_DONE;
				end else begin
					nxt.phase = PH_ERROR;
				end
			end
			PH_DONE: begin
				nxt.phase = PH_DONE;
			end
			PH_ERROR: begin
				nxt.phase = PH_ERROR;
			end
			default: begin
				nxt.phase = PH_ERROR;
			end
		endcase
		if (do_whole) begin
			if (whole_ovf) begin
				nxt.phase = PH_ERROR;
			end else begin
				nxt.whole = whole_sum[WholeW-1:0];
			end
		end
		if (do_frac && (cur.fcnt < 2'd2)) begin
			nxt.hund = hund_sum;
			nxt.fcnt = cur.fcnt + 2'd1;
		end
	end

endmodule

FILE: hdl/percent_text_to_basis_points_unit.sv
// End items pass the end_s1 input register, then the result is registered.
// One item per cycle when not stalled; parser state updates once per character.
// The end item's scaling is one constant multiply by 100 and one add/compare.
// Reset: asynchronous, active low; clears parser state, valid_s1 and res_valid.
// ----------------------------------------------------------------------------
// percent_text_to_basis_points_unit
// Streams percent text one character per transaction and returns the value
// in basis points with a valid flag when the end item arrives.
// ----------------------------------------------------------------------------
module percent_text_to_basis_points_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	output logic               stall,
	input  logic [7:0]         character,
	input  logic               end_of_text,
	output logic               res_valid,
	input  logic               res_stall,
	output logic               valid_res,
	output logic signed [31:0] basis_points
);
	import ptbp_pkg::*;

	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         end_s1;
	logic         adv_s1;
	parse_state_t state_q;
	parse_state_t state_nxt;
	logic [HundW-1:0] frac;
	logic [31:0]  mag;
	logic         mag_ovf;
	logic         phase_ok;
	logic         ok;

	ptbp_parse_step u_step (
		.cur       (state_q),
		.character (char_s1),
		.nxt       (state_nxt)
	);

	assign adv_s1 = !end_s1 || !res_valid || !res_stall;
	assign stall  = valid_s1 && !adv_s1;

	assign frac     = (state_q.fcnt == 2'd1)
		? ({state_q.hund[HundW-4:0], 3'b000} + {1'b0, state_q.hund[HundW-3:0], 1'b0})
		: state_q.hund;
	assign mag      = ({{(32-WholeW){1'b0}}, state_q.whole} * 32'd100)
		+ {{(32-HundW){1'b0}}, frac};
	assign mag_ovf  = mag[31] && (!state_q.neg || (mag[30:0] != 31'd0));
	assign phase_ok = (state_q.phase == PH_INT) || (state_q.phase == PH_FRAC)
		|| (state_q.phase == PH_TRAIL) || (state_q.phase == PH_PCT)
		|| (state_q.phase == PH_DONE);
	assign ok       = phase_ok && !mag_ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (valid && !stall) begin
			char_s1 <= character;
			end_s1  <= end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StateReset;
		end else if (valid_s1 && adv_s1) begin
			if (end_s1) begin
				state_q <= StateReset;
			end else begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (valid_s1 && end_s1 && adv_s1) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && end_s1 && adv_s1) begin
			valid_res    <= ok;
			basis_points <= !ok ? 32'sd0
				: (state_q.neg ? $signed(32'd0 - mag) : $signed(mag));
		end
	end

endmodule
